// File: rtl/core/swmr_pkg.sv
// Shared types and constants for the sliding-window mean r-squared block.
`default_nettype none
package swmr_pkg;
  localparam int unsigned MaxItems = 4096;
  localparam int unsigned SampW    = 20;
  localparam int unsigned RsqW     = 17;
  localparam int unsigned WinW     = 12;

  // Work item passed from the front part to the back part.
  typedef struct packed {
    logic [SampW-1:0] x0;
    logic [SampW-1:0] x1;
    logic [SampW-1:0] x2;
    logic [SampW-1:0] y0;
    logic [SampW-1:0] y1;
    logic [SampW-1:0] y2;
    logic             has_win;
    logic             last;
  } job_t;
endpackage
`default_nettype wire

// File: rtl/core/swmr_front.sv
// Front part: keeps the pair history and the count, builds window jobs.
`default_nettype none
module swmr_front #(
  parameter int unsigned MAX_ITEMS = swmr_pkg::MaxItems,
  parameter int unsigned CntW      = $clog2(MAX_ITEMS + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [swmr_pkg::SampW-1:0] scan_pos,
  input  wire logic [swmr_pkg::SampW-1:0] ref_size,
  input  wire logic                       last_pair,
  output logic                            q_valid,
  input  wire logic                       q_ready,
  output swmr_pkg::job_t                  q_job,
  output logic [CntW-1:0]                 q_cnt,
  output logic                            q_ovf
);
  logic [swmr_pkg::SampW-1:0] px0, px1, py0, py1;
  logic [CntW-1:0] pair_count;
  logic            overflow_seen;
  logic            take, full;

  assign in_ready = !q_valid || q_ready;
  assign take     = in_valid && in_ready;
  assign full     = (pair_count == CntW'(MAX_ITEMS));

  // history and one-entry job queue
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0; pair_count <= '0; overflow_seen <= 1'b0;
      px0 <= '0; px1 <= '0; py0 <= '0; py1 <= '0;
    end else begin
      if (q_valid && q_ready) q_valid <= 1'b0;
      if (take) begin
        q_valid <= 1'b1;
        q_job.x0 <= px0; q_job.x1 <= px1; q_job.x2 <= ref_size;
        q_job.y0 <= py0; q_job.y1 <= py1; q_job.y2 <= scan_pos;
        q_job.has_win <= !full && (pair_count >= CntW'(2));
        q_job.last <= last_pair;
        q_cnt <= full ? pair_count : pair_count + CntW'(1);
        q_ovf <= overflow_seen || full;
        if (last_pair) begin
          pair_count <= '0; overflow_seen <= 1'b0;
          px0 <= '0; px1 <= '0; py0 <= '0; py1 <= '0;
        end else if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          pair_count <= pair_count + CntW'(1);
          px0 <= px1; px1 <= ref_size; py0 <= py1; py1 <= scan_pos;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/swmr_back.sv
// Back part: window sums, r-squared division, accumulation and mean.
`default_nettype none
module swmr_back #(
  parameter int unsigned CntW = 13
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      q_valid,
  output logic                           q_ready,
  input  wire swmr_pkg::job_t            q_job,
  input  wire logic [CntW-1:0]           q_cnt,
  input  wire logic                      q_ovf,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [swmr_pkg::RsqW-1:0]      mean_rsq,
  output logic [swmr_pkg::WinW-1:0]      window_count,
  output logic                           count_overflow
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_SUM = 7'b0000010, S_MUL = 7'b0000100,
    S_DEN  = 7'b0001000, S_DIV = 7'b0010000, S_MEAN = 7'b0100000,
    S_OUT  = 7'b1000000
  } st_t;
  st_t state;
  swmr_pkg::job_t job;
  logic            ovf;
  logic [21:0] sx, sy;
  logic [43:0] sxx, syy, sxy;
  logic [45:0] num, vx, vy;
  logic [91:0] nn, dd;
  logic [108:0] dvd;
  logic [92:0]  rem;
  logic [16:0]  quo;
  logic [6:0]   step;
  logic [29:0]  acc;
  logic [CntW-1:0] wins;
  logic [93:0]  trial;
  logic [47:0]  a3, bxy, vxa, vya;
  logic [1:0]   mstep;
  logic [22:0]  na, nb, va, vb;
  logic [45:0]  np, vp;
  logic [91:0]  nadd, vadd;
  logic [16:0]  qfin, qcap;
  logic [4:0]   dstep;
  logic [29:0]  mdvd;
  logic [CntW-1:0] mrem;
  logic [CntW+1:0] mtrial;

  assign q_ready = (state == S_IDLE);
  assign trial   = {rem, dvd[108]} - {2'b00, dd};
  assign a3  = {2'b00, sxy} + {1'b0, sxy, 1'b0};
  assign bxy = 48'(sx) * 48'(sy);
  assign vxa = {2'b00, sxx} + {1'b0, sxx, 1'b0} - 48'(sx) * 48'(sx);
  assign vya = {2'b00, syy} + {1'b0, syy, 1'b0} - 48'(sy) * 48'(sy);

  // wide products built from 23-bit halves, one of four partial products per cycle
  assign na = mstep[1] ? num[45:23] : num[22:0];
  assign nb = mstep[0] ? num[45:23] : num[22:0];
  assign va = mstep[1] ? vx[45:23] : vx[22:0];
  assign vb = mstep[0] ? vy[45:23] : vy[22:0];
  assign np = 46'(na) * 46'(nb);
  assign vp = 46'(va) * 46'(vb);
  assign nadd = (mstep == 2'd0) ? {46'd0, np} :
                (mstep == 2'd3) ? {np, 46'd0} : {23'd0, np, 23'd0};
  assign vadd = (mstep == 2'd0) ? {46'd0, vp} :
                (mstep == 2'd3) ? {vp, 46'd0} : {23'd0, vp, 23'd0};

  // last quotient bit folded in, window value capped at 1.0
  assign qfin = {quo[15:0], !trial[93]};
  assign qcap = (qfin > 17'h10000) ? 17'h10000 : qfin;

  // mean divider trial subtract
  assign mtrial = {1'b0, mrem, mdvd[29]} - {2'b00, wins};

  // sequencer: sums, products, 109-step restoring division, 30-step mean division
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; acc <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (q_valid) begin
          job <= q_job; ovf <= q_ovf;
          state <= q_job.has_win ? S_SUM : (q_job.last ? S_MEAN : S_IDLE);
          wins <= (q_cnt >= CntW'(3)) ? q_cnt - CntW'(2) : '0;
          dstep <= '0;
        end
        S_SUM: begin
          sx  <= 22'(job.x0) + 22'(job.x1) + 22'(job.x2);
          sy  <= 22'(job.y0) + 22'(job.y1) + 22'(job.y2);
          sxx <= 44'(job.x0) * 44'(job.x0) + 44'(job.x1) * 44'(job.x1)
               + 44'(job.x2) * 44'(job.x2);
          syy <= 44'(job.y0) * 44'(job.y0) + 44'(job.y1) * 44'(job.y1)
               + 44'(job.y2) * 44'(job.y2);
          sxy <= 44'(job.x0) * 44'(job.y0) + 44'(job.x1) * 44'(job.y1)
               + 44'(job.x2) * 44'(job.y2);
          state <= S_MUL;
        end
        S_MUL: begin
          num <= (a3 >= bxy) ? 46'(a3 - bxy) : 46'(bxy - a3);
          vx <= 46'(vxa); vy <= 46'(vya);
          nn <= '0; dd <= '0; mstep <= '0;
          state <= S_DEN;
        end
        S_DEN: begin
          nn <= nn + nadd; dd <= dd + vadd;
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) begin
            state <= S_DIV; step <= '0;
          end
        end
        S_DIV: begin
          if (step == 7'd0) begin
            dvd <= {1'b0, nn, 16'd0}; rem <= '0; quo <= '0;
            if (dd == '0) state <= job.last ? S_MEAN : S_IDLE;
          end else begin
            dvd <= {dvd[107:0], 1'b0};
            if (!trial[93]) begin
              rem <= trial[92:0]; quo <= {quo[15:0], 1'b1};
            end else begin
              rem <= {rem[91:0], dvd[108]}; quo <= {quo[15:0], 1'b0};
            end
            if (step == 7'd109) begin
              acc <= acc + 30'(qcap);
              state <= job.last ? S_MEAN : S_IDLE;
            end
          end
          step <= step + 7'd1;
        end
        S_MEAN: begin
          if (dstep == 5'd0) begin
            mdvd <= acc; mrem <= '0;
          end else begin
            if (!mtrial[CntW+1]) begin
              mrem <= mtrial[CntW-1:0]; mdvd <= {mdvd[28:0], 1'b1};
            end else begin
              mrem <= {mrem[CntW-2:0], mdvd[29]}; mdvd <= {mdvd[28:0], 1'b0};
            end
            if (dstep == 5'd30) state <= S_OUT;
          end
          dstep <= dstep + 5'd1;
        end
        S_OUT: if (!out_valid) begin
          out_valid <= 1'b1; window_count <= swmr_pkg::WinW'(wins);
          count_overflow <= ovf;
          mean_rsq <= (wins == '0) ? '0 : mdvd[16:0];
          acc <= '0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/sliding_window_mean_r_squared.sv
// Top level: sliding-window mean of squared Pearson correlation.
// A last_pair transaction that closes a window reaches out_valid through its window
// division and the mean division; one that closes no window, through the mean only.
// A window item holds the back part in the 109-step restoring divider until done; a
// zero-variance window skips it; non-window items pass one per cycle while it idles.
// Reset (rst, synchronous) clears history, counts, accumulator and valids.
`default_nettype none
module sliding_window_mean_r_squared #(
  parameter int unsigned MAX_ITEMS = swmr_pkg::MaxItems
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [19:0] scan_pos,
  input  wire logic [19:0] ref_size,
  input  wire logic        last_pair,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [16:0]      mean_rsq,
  output logic [11:0]      window_count,
  output logic             count_overflow
);
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  logic q_valid, q_ready, q_ovf;
  swmr_pkg::job_t q_job;
  logic [CntW-1:0] q_cnt;

  swmr_front #(.MAX_ITEMS(MAX_ITEMS), .CntW(CntW)) u_front (
    .clk, .rst, .in_valid, .in_ready, .scan_pos, .ref_size, .last_pair,
    .q_valid, .q_ready, .q_job, .q_cnt, .q_ovf);

  swmr_back #(.CntW(CntW)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_job, .q_cnt, .q_ovf,
    .out_valid, .out_ready, .mean_rsq, .window_count, .count_overflow);
endmodule
`default_nettype wire
